@@ hdl/hash_gaussian_point_blend_unit_macros.svh @@
// Assertion macros for the point blend unit.
`ifndef HASH_GAUSSIAN_POINT_BLEND_UNIT_MACROS_SVH
`define HASH_GAUSSIAN_POINT_BLEND_UNIT_MACROS_SVH
`ifndef SYNTH
`define HGPB_ASSERT_IMP(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("point blend check failed");
`define HGPB_ASSERT_NEXT(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("point blend check failed");
`else
`define HGPB_ASSERT_IMP(lbl, pre, post)
`define HGPB_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

@@ hdl/hgpb_pkg.sv @@
package hgpb_pkg;

   typedef struct packed {
      logic [15:0] grid_x;
      logic [15:0] grid_y;
      logic [16:0] progress;
   } req_type;

   typedef struct packed {
      logic signed [15:0] point_x;
      logic signed [15:0] point_y;
   } rsp_type;

   localparam logic [1:0] CSR_CENTER_X = 2'd0;
   localparam logic [1:0] CSR_CENTER_Y = 2'd1;
   localparam logic [1:0] CSR_SPREAD   = 2'd2;

   localparam logic [63:0] MIX_ADD  = 64'h9e3779b97f4a7c15;
   localparam logic [63:0] MIX_MUL1 = 64'hbf58476d1ce4e5b9;
   localparam logic [63:0] MIX_MUL2 = 64'h94d049bb133111eb;

   localparam logic [30:0] TWO_LN2_Q30 = 31'd1488522236;
   localparam logic [32:0] TWO_PI_Q30  = 33'd6746518852;
   localparam logic signed [31:0] CORDIC_K_Q30 = 32'sd652032874;
   localparam int CORDIC_STEPS = 30;

   localparam logic [16:0] ONE_Q16   = 17'd65536;
   localparam logic [17:0] THREE_Q16 = 18'd196608;

   localparam logic signed [31:0] ATAN_Q30 [0:CORDIC_STEPS-1] = '{
      32'sd843314857, 32'sd497837830, 32'sd263043837, 32'sd133525159, 32'sd67021687,
      32'sd33543516, 32'sd16775851, 32'sd8388437, 32'sd4194283, 32'sd2097149,
      32'sd1048576, 32'sd524288, 32'sd262144, 32'sd131072, 32'sd65536,
      32'sd32768, 32'sd16384, 32'sd8192, 32'sd4096, 32'sd2048,
      32'sd1024, 32'sd512, 32'sd256, 32'sd128, 32'sd64,
      32'sd32, 32'sd16, 32'sd8, 32'sd4, 32'sd2
   };

endpackage

@@ hdl/hgpb_mix.sv @@
module hgpb_mix (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] key,
   output logic [63:0] hash
);
   import hgpb_pkg::*;

   logic [63:0] h0;
   logic [63:0] h1_in, h1_ff;
   logic [63:0] pl1_in, pl1_ff;
   logic [31:0] pa1_in, pa1_ff, pb1_in, pb1_ff;
   logic [63:0] h2;
   logic [63:0] h3_in, h3_ff;
   logic [63:0] pl2_in, pl2_ff;
   logic [31:0] pa2_in, pa2_ff, pb2_in, pb2_ff;
   logic [63:0] h4;
   logic [63:0] h5_in, h5_ff;
   logic [31:0] c1_lo, c1_hi, c2_lo, c2_hi;

   assign c1_lo = MIX_MUL1[31:0];
   assign c1_hi = MIX_MUL1[63:32];
   assign c2_lo = MIX_MUL2[31:0];
   assign c2_hi = MIX_MUL2[63:32];

   // Each 64-bit product modulo 2^64 is built from one full and two low-half
   // 32-bit products.
   always_comb begin
      h0     = key + MIX_ADD;
      h1_in  = h0 ^ (h0 >> 30);
      pl1_in = h1_ff[31:0] * c1_lo;
      pa1_in = h1_ff[63:32] * c1_lo;
      pb1_in = h1_ff[31:0] * c1_hi;
      h2     = pl1_ff + {pa1_ff + pb1_ff, 32'b0};
      h3_in  = h2 ^ (h2 >> 27);
      pl2_in = h3_ff[31:0] * c2_lo;
      pa2_in = h3_ff[63:32] * c2_lo;
      pb2_in = h3_ff[31:0] * c2_hi;
      h4     = pl2_ff + {pa2_ff + pb2_ff, 32'b0};
      h5_in  = h4 ^ (h4 >> 31);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         h1_ff  <= h1_in;
         pl1_ff <= pl1_in;
         pa1_ff <= pa1_in;
         pb1_ff <= pb1_in;
         h3_ff  <= h3_in;
         pl2_ff <= pl2_in;
         pa2_ff <= pa2_in;
         pb2_ff <= pb2_in;
         h5_ff  <= h5_in;
      end
   end

   assign hash = h5_ff;

endmodule

@@ hdl/hgpb_log.sv @@
module hgpb_log (
   input  logic        clock,
   input  logic        en,
   input  logic [31:0] u,
   output logic [29:0] q
);
   import hgpb_pkg::*;

   logic [31:0] u_fix;
   logic [4:0]  lead;
   logic [31:0] m_in;
   logic [5:0]  ip_in;
   logic [31:0] m_ff  [0:23];
   logic [23:0] fr_ff [0:24];
   logic [5:0]  ip_ff [0:24];
   logic [29:0] nl_in, nl_ff;
   logic [60:0] prod;
   logic [29:0] q_in, q_ff;

   // A zero uniform stands for 2^-32.
   always_comb begin
      u_fix = (u == 32'd0) ? 32'd1 : u;
      lead = 5'd0;
      for (int i = 0; i < 32; i++) begin
         if (u_fix[i]) lead = 5'(i);
      end
      m_in  = u_fix << (5'd31 - lead);
      ip_in = 6'd32 - {1'b0, lead};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_ff[0]  <= m_in;
         fr_ff[0] <= '0;
         ip_ff[0] <= ip_in;
      end
   end

   // One squaring of the mantissa per stage yields one fraction bit.
   for (genvar k = 0; k < 24; k++) begin : g_sq
      logic [63:0] sq;
      logic [23:0] fr_in;
      assign sq = m_ff[k] * m_ff[k];
      always_comb begin
         fr_in = fr_ff[k];
         if (sq[63]) fr_in[23-k] = 1'b1;
      end
      always_ff @(posedge clock) begin
         if (en) begin
            fr_ff[k+1] <= fr_in;
            ip_ff[k+1] <= ip_ff[k];
         end
      end
      if (k < 23) begin : g_m
         logic [31:0] mn_in;
         assign mn_in = sq[63] ? sq[63:32] : sq[62:31];
         always_ff @(posedge clock) begin
            if (en) m_ff[k+1] <= mn_in;
         end
      end
   end

   assign nl_in = {ip_ff[24], 24'b0} - {6'b0, fr_ff[24]};
   assign prod  = nl_ff * TWO_LN2_Q30;
   assign q_in  = prod[59:30];

   always_ff @(posedge clock) begin
      if (en) begin
         nl_ff <= nl_in;
         q_ff  <= q_in;
      end
   end

   assign q = q_ff;

endmodule

@@ hdl/hgpb_sqrt.sv @@
module hgpb_sqrt (
   input  logic        clock,
   input  logic        en,
   input  logic [29:0] q,
   output logic [27:0] root
);
   import hgpb_pkg::*;

   logic [63:0] v_ff   [1:31];
   logic [63:0] res_ff [1:32];

   // Restoring square root of q << 24, one result bit per stage.
   for (genvar i = 0; i < 32; i++) begin : g_it
      localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
      logic [63:0] v_cur, res_cur, trial, v_in, res_in;
      if (i == 0) begin : g_first
         assign v_cur   = {10'b0, q, 24'b0};
         assign res_cur = '0;
      end else begin : g_next
         assign v_cur   = v_ff[i];
         assign res_cur = res_ff[i];
      end
      always_comb begin
         trial = res_cur + BIT;
         if (v_cur >= trial) begin
            v_in   = v_cur - trial;
            res_in = (res_cur >> 1) + BIT;
         end else begin
            v_in   = v_cur;
            res_in = res_cur >> 1;
         end
      end
      always_ff @(posedge clock) begin
         if (en) res_ff[i+1] <= res_in;
      end
      if (i < 31) begin : g_v
         always_ff @(posedge clock) begin
            if (en) v_ff[i+1] <= v_in;
         end
      end
   end

   assign root = res_ff[32][27:0];

endmodule

@@ hdl/hgpb_cordic.sv @@
module hgpb_cordic (
   input  logic               clock,
   input  logic               en,
   input  logic [31:0]        turns,
   output logic signed [31:0] cos_q30,
   output logic signed [31:0] sin_q30
);
   import hgpb_pkg::*;

   localparam logic [1:0] QUAD_I   = 2'd0;
   localparam logic [1:0] QUAD_II  = 2'd1;
   localparam logic [1:0] QUAD_III = 2'd2;

   logic [62:0]        zp;
   logic signed [31:0] z0_in;
   logic signed [31:0] x_ff [1:CORDIC_STEPS];
   logic signed [31:0] y_ff [1:CORDIC_STEPS];
   logic signed [31:0] z_ff [0:CORDIC_STEPS-1];
   logic [1:0]         quad_ff [0:CORDIC_STEPS];
   logic signed [31:0] c_in, s_in, c_ff, s_ff;

   // Remainder of the quarter turn scaled to radians.
   assign zp    = turns[29:0] * TWO_PI_Q30;
   assign z0_in = $signed({1'b0, zp[62:32]});

   always_ff @(posedge clock) begin
      if (en) begin
         z_ff[0]    <= z0_in;
         quad_ff[0] <= turns[31:30];
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
      logic signed [31:0] x_cur, y_cur, dx, dy, x_in, y_in, z_in;
      if (i == 0) begin : g_first
         assign x_cur = CORDIC_K_Q30;
         assign y_cur = '0;
      end else begin : g_next
         assign x_cur = x_ff[i];
         assign y_cur = y_ff[i];
      end
      always_comb begin
         dx = y_cur >>> i;
         dy = x_cur >>> i;
         if (!z_ff[i][31]) begin
            x_in = x_cur - dx;
            y_in = y_cur + dy;
            z_in = z_ff[i] - ATAN_Q30[i];
         end else begin
            x_in = x_cur + dx;
            y_in = y_cur - dy;
            z_in = z_ff[i] + ATAN_Q30[i];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[i+1]    <= x_in;
            y_ff[i+1]    <= y_in;
            quad_ff[i+1] <= quad_ff[i];
         end
      end
      if (i < CORDIC_STEPS - 1) begin : g_z
         always_ff @(posedge clock) begin
            if (en) z_ff[i+1] <= z_in;
         end
      end
   end

   always_comb begin
      unique case (quad_ff[CORDIC_STEPS])
         QUAD_I: begin
            c_in = x_ff[CORDIC_STEPS];
            s_in = y_ff[CORDIC_STEPS];
         end
         QUAD_II: begin
            c_in = -y_ff[CORDIC_STEPS];
            s_in = x_ff[CORDIC_STEPS];
         end
         QUAD_III: begin
            c_in = -x_ff[CORDIC_STEPS];
            s_in = -y_ff[CORDIC_STEPS];
         end
         default: begin
            c_in = y_ff[CORDIC_STEPS];
            s_in = -x_ff[CORDIC_STEPS];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_ff <= c_in;
         s_ff <= s_in;
      end
   end

   assign cos_q30 = c_ff;
   assign sin_q30 = s_ff;

endmodule

@@ hdl/hash_gaussian_point_blend_unit.sv @@
// Throughput: one item per cycle while req_stall is low; the 32-stage
// square root after the 27-stage logarithm sets the depth, and every
// stage holds one item.
// A two-entry output register and skid stage let the pipeline run on while a
// result waits; a full skid stage raises req_stall.
// Reset is synchronous and active high; it empties the pipeline and restores the
// centre and spread registers.
`include "hash_gaussian_point_blend_unit_macros.svh"

module hash_gaussian_point_blend_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  hgpb_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output hgpb_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [11:0]       csr_data
);
   import hgpb_pkg::*;

   localparam int SM_STG   = 3;
   localparam int COS_STG  = 37;
   localparam int ROOT_STG = 64;
   localparam int TGT_STG  = ROOT_STG + 2;
   localparam int LAST_STG = ROOT_STG + 4;
   localparam int CS_DEPTH = ROOT_STG - COS_STG;
   localparam int G_DEPTH  = TGT_STG;
   localparam int SM_DEPTH = TGT_STG - SM_STG + 1;

   localparam logic signed [59:0] HALF_Q40  = 60'sh8000000000;
   localparam logic signed [59:0] TRUNC_ADJ = 60'shFFFFFFFFFF;

   function automatic logic signed [15:0] round_sat(input logic signed [59:0] v);
      logic signed [59:0] adj;
      logic signed [19:0] r;
      adj = v + (v[59] ? TRUNC_ADJ : 60'sd0);
      r   = adj[59:40];
      if (r > 20'sd32767) return 16'sh7fff;
      else if (r < -20'sd32768) return 16'sh8000;
      else return r[15:0];
   endfunction

   logic adv;
   logic [LAST_STG:1] vld_ff, vld_in;

   logic [11:0] center_x_ff, center_y_ff;
   logic [9:0]  spread_ff;

   logic [63:0]        hash;
   logic [29:0]        q;
   logic [27:0]        root;
   logic signed [31:0] cos_q30, sin_q30;

   logic [16:0] pr_c;
   logic [32:0] p2_in, p2_ff;
   logic [17:0] w_in, w_ff;
   logic [48:0] s48_in, s48_ff, sm_sum;
   logic [16:0] sm_in;

   logic [16:0] sm_dly_ff [0:SM_DEPTH-1];
   logic [31:0] g_dly_ff  [0:G_DEPTH-1];
   logic [63:0] cs_dly_ff [0:CS_DEPTH-1];

   logic signed [60:0] prx, pry;
   logic signed [28:0] nx_in, ny_in, nx_ff, ny_ff;
   logic signed [10:0] spread_s;
   logic signed [39:0] tx_in, ty_in, tx_ff, ty_ff;
   logic [16:0]        sm_t, gw;
   logic [15:0]        gx_t, gy_t;
   logic [32:0]        ax_in, ay_in, ax_ff, ay_ff;
   logic signed [57:0] bx_in, by_in, bx_ff, by_ff;
   logic signed [59:0] vx_in, vy_in, vx_ff, vy_ff;

   rsp_type fin;
   logic    take;
   logic    rsp_valid_in, rsp_valid_ff, skid_full_in, skid_full_ff;
   rsp_type rsp_data_in, rsp_data_ff, skid_data_in, skid_data_ff;

   assign adv       = !skid_full_ff;
   assign req_stall = skid_full_ff;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= 12'd960;
         center_y_ff <= 12'd540;
         spread_ff   <= 10'd170;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_CENTER_X: center_x_ff <= csr_data;
            CSR_CENTER_Y: center_y_ff <= csr_data;
            CSR_SPREAD:   spread_ff   <= csr_data[9:0];
            default: ;
         endcase
      end
   end

   assign vld_in = {vld_ff[LAST_STG-1:1], req_valid};

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (adv) vld_ff <= vld_in;
   end

   hgpb_mix u_mix (
      .clock (clock),
      .en    (adv),
      .key   ({16'b0, req_data.grid_y, 16'b0, req_data.grid_x}),
      .hash  (hash)
   );

   hgpb_log u_log (
      .clock (clock),
      .en    (adv),
      .u     (hash[31:0]),
      .q     (q)
   );

   hgpb_sqrt u_sqrt (
      .clock (clock),
      .en    (adv),
      .q     (q),
      .root  (root)
   );

   hgpb_cordic u_cordic (
      .clock   (clock),
      .en      (adv),
      .turns   (hash[63:32]),
      .cos_q30 (cos_q30),
      .sin_q30 (sin_q30)
   );

   // Smoothstep of the progress, 3p^2 - 2p^3 rounded to Q1.16.
   always_comb begin
      pr_c   = (req_data.progress > ONE_Q16) ? ONE_Q16 : req_data.progress;
      p2_in  = pr_c * pr_c;
      w_in   = THREE_Q16 - {pr_c, 1'b0};
      s48_in = p2_ff * w_ff;
      sm_sum = s48_ff + 49'h0_0000_8000_0000;
      sm_in  = sm_sum[48:32];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p2_ff        <= p2_in;
         w_ff         <= w_in;
         s48_ff       <= s48_in;
         sm_dly_ff[0] <= sm_in;
         g_dly_ff[0]  <= {req_data.grid_y, req_data.grid_x};
         cs_dly_ff[0] <= {cos_q30, sin_q30};
         for (int j = 1; j < SM_DEPTH; j++) sm_dly_ff[j] <= sm_dly_ff[j-1];
         for (int j = 1; j < G_DEPTH; j++) g_dly_ff[j] <= g_dly_ff[j-1];
         for (int j = 1; j < CS_DEPTH; j++) cs_dly_ff[j] <= cs_dly_ff[j-1];
      end
   end

   always_comb begin
      prx      = $signed({1'b0, root}) * $signed(cs_dly_ff[CS_DEPTH-1][63:32]);
      pry      = $signed({1'b0, root}) * $signed(cs_dly_ff[CS_DEPTH-1][31:0]);
      nx_in    = prx[58:30];
      ny_in    = pry[58:30];
      spread_s = $signed({1'b0, spread_ff});
      tx_in    = $signed({4'b0, center_x_ff, 24'b0}) + nx_ff * spread_s;
      ty_in    = $signed({4'b0, center_y_ff, 24'b0}) + ny_ff * spread_s;
      sm_t     = sm_dly_ff[SM_DEPTH-1];
      gx_t     = g_dly_ff[G_DEPTH-1][15:0];
      gy_t     = g_dly_ff[G_DEPTH-1][31:16];
      gw       = ONE_Q16 - sm_t;
      ax_in    = gx_t * gw;
      ay_in    = gy_t * gw;
      bx_in    = tx_ff * $signed({1'b0, sm_t});
      by_in    = ty_ff * $signed({1'b0, sm_t});
      vx_in    = $signed({3'b0, ax_ff, 24'b0}) + {{2{bx_ff[57]}}, bx_ff} + HALF_Q40;
      vy_in    = $signed({3'b0, ay_ff, 24'b0}) + {{2{by_ff[57]}}, by_ff} + HALF_Q40;
      fin.point_x = round_sat(vx_ff);
      fin.point_y = round_sat(vy_ff);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         nx_ff <= nx_in;
         ny_ff <= ny_in;
         tx_ff <= tx_in;
         ty_ff <= ty_in;
         ax_ff <= ax_in;
         ay_ff <= ay_in;
         bx_ff <= bx_in;
         by_ff <= by_in;
         vx_ff <= vx_in;
         vy_ff <= vy_in;
      end
   end

   // The skid stage catches the item leaving the pipeline while the output
   // register is stalled; the pipeline then freezes until it drains.
   always_comb begin
      take         = rsp_valid_ff && !rsp_stall;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      skid_full_in = skid_full_ff;
      skid_data_in = skid_data_ff;
      if (skid_full_ff) begin
         if (take) begin
            rsp_data_in  = skid_data_ff;
            rsp_valid_in = 1'b1;
            skid_full_in = 1'b0;
         end
      end else if (vld_ff[LAST_STG]) begin
         if (!rsp_valid_ff || take) begin
            rsp_data_in  = fin;
            rsp_valid_in = 1'b1;
         end else begin
            skid_data_in = fin;
            skid_full_in = 1'b1;
         end
      end else if (take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         skid_full_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         skid_full_ff <= skid_full_in;
      end
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `HGPB_ASSERT_IMP(a_skid_behind_out, skid_full_ff, rsp_valid_ff)
   `HGPB_ASSERT_NEXT(a_skid_fill, rsp_valid_ff && rsp_stall && vld_ff[LAST_STG] && !skid_full_ff, skid_full_ff)
   `HGPB_ASSERT_NEXT(a_skid_drain, skid_full_ff && !rsp_stall, !skid_full_ff && rsp_valid_ff)

endmodule
